>>> rtl/ccs_pkg.sv
// shared constants and types for the cyclic code encoder and syndrome checker
`default_nettype none

package ccs_pkg;

  localparam int MaxCheckBits = 32;
  localparam int MaxWordBits  = 64;
  localparam int WordW        = MaxWordBits;
  localparam int GenW         = 32;
  localparam int FieldW       = 6;
  localparam int CountW       = $clog2(MaxWordBits + 1);
  localparam int ShiftW       = $clog2(MaxWordBits);
  localparam int CheckLim     = (MaxCheckBits < MaxWordBits - 1) ? MaxCheckBits
                                                                 : MaxWordBits - 1;
  localparam int DivSteps      = MaxWordBits - 1;
  localparam int StepsPerStage = 8;
  localparam int DivStages     = (DivSteps + StepsPerStage - 1) / StepsPerStage;
  localparam int CfgIdxW       = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGenPoly   = 2'd0,
    CfgCheckBits = 2'd1,
    CfgDataBits  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpEncode = 1'b0,
    OpCheck  = 1'b1
  } op_e;

  // one word in flight through the divider, all left-aligned to the msb
  typedef struct packed {
    logic [WordW-1:0]  w;
    logic [WordW-1:0]  orig;
    logic [WordW-1:0]  gen;
    logic [FieldW-1:0] k;
    logic [CountW-1:0] n;
    op_e               op;
  } div_item_t;

endpackage

`default_nettype wire

>>> rtl/cyclic_code_encode_and_syndrome_top.sv
// Systematic cyclic code encoder and syndrome checker over GF(2).
//
// Input: a word is taken at a rising edge with start_i high and busy_o low.
// busy_o is always low, so a new word can be given in every cycle.
// op_i selects encode (message in the low k bits of data_word_i) or check
// (received word in the low k+r bits). Excess high bits are ignored.
// Output: done_o is high for exactly one cycle per word, together with
// result_word_o (codeword, or syndrome in the low r bits) and
// syndrome_nonzero_o. Results leave in input order.
// The path from accept to result runs through these registers in order:
// one input stage, one alignment stage, eight divider stages of up to eight
// conditional xor steps each (63 in all), and one output stage. Throughput
// is one word per cycle.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 generator low coefficients, 1 degree r, 2 message length k); other
// indexes are ignored. Write only while no word is in flight.
// Reset clears the pipeline valid bits and loads g = x^3+x+1, r = 3, k = 4.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module cyclic_code_encode_and_syndrome_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic                          op_i,
  input  wire logic [ccs_pkg::WordW-1:0]     data_word_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ccs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ccs_pkg::GenW-1:0]      cfg_wdata_i,
  output      logic                          done_o,
  output      logic [ccs_pkg::WordW-1:0]     result_word_o,
  output      logic                          syndrome_nonzero_o
);

  localparam int WordW  = ccs_pkg::WordW;
  localparam int FieldW = ccs_pkg::FieldW;
  localparam int CountW = ccs_pkg::CountW;
  localparam int ShiftW = ccs_pkg::ShiftW;
  localparam int GenW   = ccs_pkg::GenW;
  localparam int NStage = ccs_pkg::DivStages;
  localparam int Spp    = ccs_pkg::StepsPerStage;

  // configuration registers
  logic [GenW-1:0]   gen_poly_q;
  logic [FieldW-1:0] check_bits_q;
  logic [FieldW-1:0] data_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_poly_q   <= GenW'(3);
      check_bits_q <= FieldW'(3);
      data_bits_q  <= FieldW'(4);
    end else if (cfg_we_i) begin
      case (ccs_pkg::cfg_idx_e'(cfg_idx_i))
        ccs_pkg::CfgGenPoly:   gen_poly_q   <= cfg_wdata_i;
        ccs_pkg::CfgCheckBits: check_bits_q <= cfg_wdata_i[FieldW-1:0];
        ccs_pkg::CfgDataBits:  data_bits_q  <= cfg_wdata_i[FieldW-1:0];
        default: ;
      endcase
    end
  end

  // saturated degree and lengths
  logic [FieldW-1:0] r_eff;
  logic [FieldW-1:0] k_eff;
  logic [CountW-1:0] k_lim;
  logic [CountW-1:0] n_eff;

  always_comb begin
    r_eff = check_bits_q;
    if (check_bits_q == '0) begin
      r_eff = FieldW'(1);
    end else if (check_bits_q > FieldW'(ccs_pkg::CheckLim)) begin
      r_eff = FieldW'(ccs_pkg::CheckLim);
    end
    k_lim = CountW'(ccs_pkg::MaxWordBits) - CountW'(r_eff);
    k_eff = data_bits_q;
    if (data_bits_q == '0) begin
      k_eff = FieldW'(1);
    end else if (CountW'(data_bits_q) > k_lim) begin
      k_eff = k_lim[FieldW-1:0];
    end
    n_eff = CountW'(k_eff) + CountW'(r_eff);
  end

  assign busy_o = 1'b0;

  // input stage
  logic              in_valid_q;
  ccs_pkg::op_e      in_op_q;
  logic [WordW-1:0]  in_data_q;
  logic [FieldW-1:0] in_r_q;
  logic [FieldW-1:0] in_k_q;
  logic [CountW-1:0] in_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_op_q   <= ccs_pkg::op_e'(op_i);
      in_data_q <= data_word_i;
      in_r_q    <= r_eff;
      in_k_q    <= k_eff;
      in_n_q    <= n_eff;
    end
  end

  // alignment stage: word and generator moved up to the msb
  logic [ShiftW-1:0]  sh_enc;
  logic [ShiftW-1:0]  sh_chk;
  logic [ShiftW-1:0]  sh_gen;
  logic [WordW-1:0]   aligned;
  ccs_pkg::div_item_t align_d;

  always_comb begin
    sh_enc = ShiftW'(CountW'(ccs_pkg::MaxWordBits) - CountW'(in_k_q));
    sh_chk = ShiftW'(CountW'(ccs_pkg::MaxWordBits) - in_n_q);
    sh_gen = ShiftW'(CountW'(ccs_pkg::MaxWordBits - 1) - CountW'(in_r_q));
    if (in_op_q == ccs_pkg::OpCheck) begin
      aligned = in_data_q << sh_chk;
    end else begin
      aligned = in_data_q << sh_enc;
    end
    align_d.w    = aligned;
    align_d.orig = aligned;
    // coefficients at r and above fall off the top
    align_d.gen  = {1'b1, (WordW - 1)'(gen_poly_q) << sh_gen};
    align_d.k    = in_k_q;
    align_d.n    = in_n_q;
    align_d.op   = in_op_q;
  end

  logic               div_valid_q [NStage+1];
  ccs_pkg::div_item_t div_q       [NStage+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q[0] <= 1'b0;
    end else begin
      div_valid_q[0] <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= align_d;
  end

  // divider stages, each handles the next group of message bits from the top
  for (genvar s = 0; s < NStage; s++) begin : g_div
    ccs_pkg::div_item_t step_d;

    always_comb begin
      step_d = div_q[s];
      for (int i = 0; i < Spp; i++) begin
        if (s * Spp + i < ccs_pkg::DivSteps) begin
          if ((CountW'(s * Spp + i) < CountW'(step_d.k)) &&
              step_d.w[WordW - 1 - (s * Spp + i)]) begin
            step_d.w = step_d.w ^ (step_d.gen >> (s * Spp + i));
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[s+1] <= 1'b0;
      end else begin
        div_valid_q[s+1] <= div_valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[s+1] <= step_d;
    end
  end

  // output stage: shift back down to the lsb
  ccs_pkg::div_item_t last;
  logic [ShiftW-1:0]  sh_out;
  logic [WordW-1:0]   result_d;
  logic               nz;
  logic               done_q;
  logic               syn_q;
  logic [WordW-1:0]   result_q;

  always_comb begin
    last   = div_q[NStage];
    sh_out = ShiftW'(CountW'(ccs_pkg::MaxWordBits) - last.n);
    nz     = |last.w;
    if (last.op == ccs_pkg::OpCheck) begin
      result_d = last.w >> sh_out;
    end else begin
      result_d = (last.orig | last.w) >> sh_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      syn_q  <= 1'b0;
    end else begin
      done_q <= div_valid_q[NStage];
      syn_q  <= div_valid_q[NStage] && (last.op == ccs_pkg::OpCheck) && nz;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o             = done_q;
  assign syndrome_nonzero_o = syn_q;
  assign result_word_o      = result_q;

`ifndef SYNTHESIS
  // every quotient bit has been cleared by the last divider stage
  a_quotient_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid_q[NStage] |->
      ((last.w >> ShiftW'(CountW'(ccs_pkg::MaxWordBits) - CountW'(last.k))) == '0))
    else $error("divider left a quotient bit set");

  // nothing below the codeword's lsb position
  a_no_low_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid_q[NStage] |-> ((last.w << last.n) == '0))
    else $error("divider wrote below the word");

  a_flag_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    syndrome_nonzero_o |-> done_o)
    else $error("syndrome flag without result");

  a_flag_matches_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    syndrome_nonzero_o |-> (result_word_o != '0))
    else $error("syndrome flag set on zero syndrome");

  a_syndrome_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    syndrome_nonzero_o |-> ((result_word_o >> ccs_pkg::MaxCheckBits) == '0))
    else $error("syndrome wider than the check bits");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_cyclic_code_encode_and_syndrome_top.sv
// testbench for the cyclic code encoder and syndrome checker, checked against a GF(2) divider
module tb_cyclic_code_encode_and_syndrome_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 4;
  localparam int Latency    = 11;
  localparam int StallLimit = 1000;
  localparam int PhaseWords = 650;
  localparam int SettingRun = 50;
  localparam int WordW      = ccs_pkg::WordW;
  localparam int GenW       = ccs_pkg::GenW;
  localparam int FieldW     = ccs_pkg::FieldW;
  localparam int CfgIdxW    = ccs_pkg::CfgIdxW;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             nz;
  } codec_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 op_i;
  logic [WordW-1:0]     data_word_i;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [GenW-1:0]      cfg_wdata_i;
  logic                 done_o;
  logic [WordW-1:0]     result_word_o;
  logic                 syndrome_nonzero_o;

  // register copies, loaded with the reset values
  logic [GenW-1:0]   gen_low_q = 32'd3;
  logic [FieldW-1:0] degree_q  = 6'd3;
  logic [FieldW-1:0] msg_len_q = 6'd4;

  codec_result_t pending_results[$];
  int errors = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  cyclic_code_encode_and_syndrome_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .op_i               (op_i),
    .data_word_i        (data_word_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .result_word_o      (result_word_o),
    .syndrome_nonzero_o (syndrome_nonzero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic logic [WordW-1:0] low_ones(input int bits);
    if (bits >= WordW) return {WordW{1'b1}};
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic int parity_width();
    int r;
    int lim;
    r = int'(degree_q);
    lim = ccs_pkg::CheckLim;
    if (r < 1) r = 1;
    if (r > lim) r = lim;
    return r;
  endfunction

  // message length saturates so the codeword never exceeds the word
  function automatic int message_width();
    int k;
    k = int'(msg_len_q);
    if (k < 1) k = 1;
    if (k > ccs_pkg::MaxWordBits - parity_width()) k = ccs_pkg::MaxWordBits - parity_width();
    return k;
  endfunction

  function automatic logic [WordW-1:0] gf2_remainder(
      input logic [WordW-1:0] dividend, input int n, input int r);
    logic [WordW-1:0] divisor;
    divisor = (64'd1 << r) | ({32'd0, gen_low_q} & low_ones(r));
    for (int i = n; i > r; i--) begin
      if (dividend[i-1]) dividend ^= divisor << (i - 1 - r);
    end
    return dividend & low_ones(r);
  endfunction

  function automatic codec_result_t predict_result(input ccs_pkg::op_e op,
                                                   input logic [WordW-1:0] din);
    codec_result_t res;
    int r;
    int k;
    logic [WordW-1:0] shifted;
    r = parity_width();
    k = message_width();
    if (op == ccs_pkg::OpEncode) begin
      shifted = (din & low_ones(k)) << r;
      res.word = shifted | gf2_remainder(shifted, k + r, r);
      res.nz = 1'b0;
    end else begin
      res.word = gf2_remainder(din & low_ones(k + r), k + r, r);
      res.nz = (res.word != '0);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] want,
                                 input logic [WordW-1:0] got);
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  task automatic send_word(input ccs_pkg::op_e op, input logic [WordW-1:0] din);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      op_i <= 1'($urandom_range(1));
      data_word_i <= {$urandom(), $urandom()};
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    data_word_i <= din;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results = {pending_results, predict_result(op, din)};
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GenW-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ccs_pkg::CfgGenPoly:   gen_low_q = value;
      ccs_pkg::CfgCheckBits: degree_q = value[FieldW-1:0];
      ccs_pkg::CfgDataBits:  msg_len_q = value[FieldW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    codec_result_t cw;
    send_word(ccs_pkg::OpEncode, '0);
    send_word(ccs_pkg::OpEncode, 64'hF);
    send_word(ccs_pkg::OpEncode, '1);
    send_word(ccs_pkg::OpCheck, '0);
    send_word(ccs_pkg::OpCheck, '1);
    cw = predict_result(ccs_pkg::OpEncode, 64'hB);
    send_word(ccs_pkg::OpCheck, cw.word);
    send_word(ccs_pkg::OpCheck, cw.word ^ 64'h40);
    send_word(ccs_pkg::OpCheck, 64'h1);
  endtask

  task automatic test_degree_limits();
    // zero degree and zero length both saturate to one bit
    write_reg(ccs_pkg::CfgCheckBits, '0);
    write_reg(ccs_pkg::CfgDataBits, '0);
    send_word(ccs_pkg::OpEncode, '1);
    send_word(ccs_pkg::OpCheck, '1);
    send_word(ccs_pkg::OpCheck, 64'h2);
    // degree above the limit clamps to 32, length clamps to the rest of the word
    write_reg(ccs_pkg::CfgGenPoly, '1);
    write_reg(ccs_pkg::CfgCheckBits, 32'd40);
    write_reg(ccs_pkg::CfgDataBits, 32'd63);
    send_word(ccs_pkg::OpEncode, '1);
    send_word(ccs_pkg::OpEncode, 64'h8000_0001);
    send_word(ccs_pkg::OpCheck, '1);
    send_word(ccs_pkg::OpCheck, 64'h1_0000_0000);
    // upper write bits dropped, degree one gives a 63-bit message
    write_reg(ccs_pkg::CfgCheckBits, 32'hFFFF_FFC1);
    send_word(ccs_pkg::OpEncode, '1);
    send_word(ccs_pkg::OpCheck, '1);
    write_reg(ccs_pkg::CfgGenPoly, '0);
    write_reg(ccs_pkg::CfgCheckBits, 32'd32);
    write_reg(ccs_pkg::CfgDataBits, 32'd32);
    send_word(ccs_pkg::OpEncode, '1);
    send_word(ccs_pkg::OpCheck, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_ignored_register();
    write_reg(CfgUnused, '1);
    send_word(ccs_pkg::OpEncode, 64'h5A5A_5A5A_5A5A_5A5A);
    send_word(ccs_pkg::OpCheck, '1);
  endtask

  task automatic random_settings();
    int r;
    int k;
    r = ($urandom_range(7) == 0) ? $urandom_range(63)
                                 : $urandom_range(1, ccs_pkg::MaxCheckBits);
    k = ($urandom_range(7) == 0) ? $urandom_range(63)
                                 : $urandom_range(1, ccs_pkg::MaxWordBits - 1);
    write_reg(ccs_pkg::CfgGenPoly, $urandom());
    write_reg(ccs_pkg::CfgCheckBits, ($urandom() & 32'hFFFF_FFC0) | 32'(r));
    write_reg(ccs_pkg::CfgDataBits, ($urandom() & 32'hFFFF_FFC0) | 32'(k));
    if ($urandom_range(3) == 0) write_reg(CfgUnused, $urandom());
  endtask

  task automatic send_random_word();
    logic [WordW-1:0] din;
    codec_result_t cw;
    int n;
    int pos;
    n = message_width() + parity_width();
    din = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0, 1, 2, 3: send_word(ccs_pkg::OpEncode, din);
      4, 5, 6, 7: begin
        // valid codeword with up to three flipped bits, sometimes junk above the word
        cw = predict_result(ccs_pkg::OpEncode, din);
        din = cw.word;
        repeat ($urandom_range(3)) begin
          pos = $urandom_range(n - 1);
          din[pos] = ~din[pos];
        end
        if ($urandom_range(3) == 0) din |= {$urandom(), $urandom()} & ~low_ones(n);
        send_word(ccs_pkg::OpCheck, din);
      end
      default: send_word(ccs_pkg::OpCheck, din);
    endcase
  endtask

  task automatic test_random_traffic(input int pct, input int words);
    idle_pct = pct;
    for (int i = 0; i < words; i++) begin
      if (i % SettingRun == 0) random_settings();
      else if ($urandom_range(99) == 0) wait_idle();
      send_random_word();
    end
  endtask

  always @(posedge clk_i) begin : check_results
    codec_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", '0, result_word_o);
      end else begin
        want = pending_results.pop_front();
        if (result_word_o !== want.word)
          report_mismatch("result_word", want.word, result_word_o);
        if (syndrome_nonzero_o !== want.nz)
          report_mismatch("syndrome_nonzero", 64'(want.nz), 64'(syndrome_nonzero_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    op_i <= ccs_pkg::OpEncode;
    data_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= ccs_pkg::CfgGenPoly;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_degree_limits();
    test_ignored_register();
    test_random_traffic(34, PhaseWords);
    test_random_traffic(83, PhaseWords);
    test_random_traffic(0, PhaseWords);
    wait_idle();
    repeat (2 * Latency) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> cyclic_code_encode_and_syndrome_top.f
rtl/ccs_pkg.sv
rtl/cyclic_code_encode_and_syndrome_top.sv
tb/sv/tb_cyclic_code_encode_and_syndrome_top.sv
